// ===== src/rdc_pkg.sv =====
// Shared types, constants and the digit character map of the radix digit converter.
package rdc_pkg;

  localparam int unsigned BASE_W = 6;
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned DCNT_W = 6;
  localparam int unsigned DIV_STEPS = 8;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_LSD_FIRST = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 7'd55;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {1'b0, d};
    end else if (d < BASE_MAX) begin
      c = CHAR_ALPHA_OFS + {1'b0, d};
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// ===== src/radix_digit_converter_top.sv =====
// Top level of the radix digit converter: config registers, front, job queue, RAM, back.
//
// Input stream (s_axis): one unsigned value per item in tdata.
// Output stream (m_axis): one item per digit as an ASCII character
// ('0'-'9', 'A'-'Z'); tlast marks the final digit, which also carries the
// digit count. A zero value yields the single digit '0'.
// APB registers: 0x0 base (2..36, writes saturate, reset 10), 0x4 lsd_first
// (reset 0: most significant digit first). Write them only while idle.
// The front divides with a restoring divider that resolves 8 quotient bits
// per cycle, one digit per pass over the value, and writes each digit into
// the RAM. The back passes each digit through the RAM's registered read and
// a pending stage into the output register, and it issues no new read while
// a read is still pending.
// Two digit buffers in the RAM and a two-entry job queue let the front
// convert the next value while the back still emits the previous one.
// A stalled receiver holds the output register; once both buffers are
// full the input stalls. Reset empties the queue and restores the
// register defaults; no clearing pass is needed.
module radix_digit_converter_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // s_axis_tdata: value
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // m_axis_tdata: digit_char[6:0], digit_count[12:7], zero pad
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [15:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import rdc_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_BITS + 1);
  localparam int unsigned IW = $clog2(VALUE_BITS);
  localparam int unsigned JW = CW + 1;
  localparam int unsigned AW = IW + 1;
  localparam int unsigned DEPTH = 2 * (2 ** IW);

  logic [BASE_W-1:0] base_q, base_d;
  logic              lsd_first_q, lsd_first_d;
  logic              cfg_we;
  logic [BASE_W-1:0] wr_base;

  fifo_stat_t        fifo_stat;
  logic              job_push, job_pop;
  logic [JW-1:0]     push_job, head_job;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BASE_W-1:0] ram_wdata, ram_rdata;
  logic [CHAR_W-1:0] digit_char_w;
  logic [DCNT_W-1:0] digit_count_w;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign wr_base = pwdata[BASE_W-1:0];

  always_comb begin
    base_d      = base_q;
    lsd_first_d = lsd_first_q;
    if (cfg_we) begin
      case (paddr[2])
        REG_BASE: begin
          if (wr_base < BASE_MIN) begin
            base_d = BASE_MIN;
          end else if (wr_base > BASE_MAX) begin
            base_d = BASE_MAX;
          end else begin
            base_d = wr_base;
          end
        end
        REG_LSD_FIRST: lsd_first_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_RESET;
      lsd_first_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      lsd_first_q <= lsd_first_d;
    end
  end

  assign prdata = (paddr[2] == REG_LSD_FIRST) ? {31'd0, lsd_first_q} : {26'd0, base_q};

  rdc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .value_i     (s_axis_tdata[VALUE_BITS-1:0]),
    .base_i      (base_q),
    .lsd_first_i (lsd_first_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (job_push),
    .push_job_o  (push_job),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  rdc_job_fifo #(.WIDTH(JW)) u_job_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (push_job),
    .pop_i       (job_pop),
    .head_o      (head_job),
    .stat_o      (fifo_stat)
  );

  rdc_ram #(.WIDTH(BASE_W), .DEPTH(DEPTH)) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rdc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_stat_i   (fifo_stat),
    .head_job_i    (head_job),
    .pop_o         (job_pop),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .digit_char_o  (digit_char_w),
    .last_o        (m_axis_tlast),
    .digit_count_o (digit_count_w)
  );

  assign m_axis_tdata = {3'd0, digit_count_w, digit_char_w};

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !fifo_stat.full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> fifo_stat.not_empty)
    else $error("job popped from an empty queue");

  a_base_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q >= BASE_MIN) && (base_q <= BASE_MAX))
    else $error("base register out of range");

  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !job_push)
    else $error("job pushed right after an item was accepted");

endmodule

// ===== src/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rdc_job_fifo.sv =====
// Two-entry queue of finished conversion jobs between front and back.
module rdc_job_fifo #(
  parameter int unsigned WIDTH = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    push_data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    head_o,
  output rdc_pkg::fifo_stat_t stat_o
);
  import rdc_pkg::*;

  logic [WIDTH-1:0] data_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o           = data_q[rd_ptr_q];
  assign stat_o.full      = cnt_q[1];
  assign stat_o.not_empty = (cnt_q != 2'd0);

endmodule

// ===== src/rdc_front.sv =====
// Front end: accepts values and divides them into digits, least significant first.
module rdc_front #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_valid_i,
  output logic                                       s_ready_o,
  input  logic [VALUE_BITS-1:0]                      value_i,
  input  logic [rdc_pkg::BASE_W-1:0]                 base_i,
  input  logic                                       lsd_first_i,
  input  rdc_pkg::fifo_stat_t                        fifo_stat_i,
  output logic                                       push_o,
  output logic [$clog2(VALUE_BITS+1):0]              push_job_o,
  output logic                                       ram_we_o,
  output logic [$clog2(VALUE_BITS):0]                ram_waddr_o,
  output logic [rdc_pkg::BASE_W-1:0]                 ram_wdata_o
);
  import rdc_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_BITS + 1);
  localparam int unsigned IW = $clog2(VALUE_BITS);
  localparam int unsigned CHUNKS = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned PADW = CHUNKS * DIV_STEPS;
  localparam int unsigned KW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e            state_q, state_d;
  logic [PADW-1:0]   div_q, div_d;
  logic [BASE_W-1:0] rem_q, rem_d;
  logic [KW-1:0]     chunk_q, chunk_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              slot_q, slot_d;

  logic [BASE_W:0]    r;
  logic [DIV_STEPS-1:0] qbits;
  logic [PADW-1:0]    quo;
  logic               last_chunk;

  // restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    r = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[BASE_W-1:0], div_q[PADW-1-i]};
      if (r >= {1'b0, base_i}) begin
        r = r - {1'b0, base_i};
        qbits[DIV_STEPS-1-i] = 1'b1;
      end
    end
  end

  assign quo = (div_q << DIV_STEPS) | PADW'(qbits);
  assign last_chunk = (chunk_q == KW'(CHUNKS - 1));

  always_comb begin
    state_d = state_q;
    div_d   = div_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    cnt_d   = cnt_q;
    slot_d  = slot_q;
    push_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i && !fifo_stat_i.full) begin
          div_d   = PADW'(value_i);
          rem_d   = '0;
          chunk_d = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_d   = quo;
        rem_d   = r[BASE_W-1:0];
        chunk_d = chunk_q + KW'(1);
        if (last_chunk) begin
          cnt_d   = cnt_q + CW'(1);
          rem_d   = '0;
          chunk_d = '0;
          if (quo == '0) begin
            push_o  = 1'b1;
            slot_d  = ~slot_q;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= 1'b0;
      chunk_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      chunk_q <= chunk_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign s_ready_o   = (state_q == ST_IDLE) && !fifo_stat_i.full;
  assign push_job_o  = {lsd_first_i, cnt_d};
  assign ram_we_o    = (state_q == ST_DIV) && last_chunk;
  assign ram_waddr_o = {slot_q, cnt_q[IW-1:0]};
  assign ram_wdata_o = r[BASE_W-1:0];

endmodule

// ===== src/rdc_back.sv =====
// Back end: reads stored digits in the requested order and drives the result stream.
module rdc_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rdc_pkg::fifo_stat_t               fifo_stat_i,
  input  logic [$clog2(VALUE_BITS+1):0]     head_job_i,
  output logic                              pop_o,
  output logic [$clog2(VALUE_BITS):0]       ram_raddr_o,
  input  logic [rdc_pkg::BASE_W-1:0]        ram_rdata_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [rdc_pkg::CHAR_W-1:0]        digit_char_o,
  output logic                              last_o,
  output logic [rdc_pkg::DCNT_W-1:0]        digit_count_o
);
  import rdc_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_BITS + 1);
  localparam int unsigned IW = $clog2(VALUE_BITS);
  localparam int unsigned EXT_W = CW + DCNT_W;

  logic [CW-1:0]     k_q, k_d;
  logic              slot_q, slot_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic [DCNT_W-1:0] pend_cnt_q, pend_cnt_d;
  logic              out_v_q, out_v_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic [DCNT_W-1:0] out_cnt_q, out_cnt_d;

  logic [CW-1:0]    job_cnt;
  logic             job_lsd;
  logic [CW-1:0]    idx;
  logic             is_last;
  logic             issue;
  logic [EXT_W-1:0] cnt_ext;

  assign job_cnt = head_job_i[CW-1:0];
  assign job_lsd = head_job_i[CW];
  assign idx     = job_lsd ? k_q : (job_cnt - CW'(1) - k_q);
  assign is_last = (k_q == job_cnt - CW'(1));
  assign issue   = fifo_stat_i.not_empty && !pend_q && (!out_v_q || m_ready_i);
  assign cnt_ext = EXT_W'(job_cnt);

  always_comb begin
    k_d         = k_q;
    slot_d      = slot_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    pend_cnt_d  = pend_cnt_q;
    out_v_d     = out_v_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_cnt_d   = out_cnt_q;
    pop_o       = 1'b0;

    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = is_last;
      pend_cnt_d  = is_last ? cnt_ext[DCNT_W-1:0] : '0;
      if (is_last) begin
        k_d    = '0;
        slot_d = ~slot_q;
        pop_o  = 1'b1;
      end else begin
        k_d = k_q + CW'(1);
      end
    end

    if (pend_q) begin
      out_v_d    = 1'b1;
      out_char_d = digit_char(ram_rdata_i);
      out_last_d = pend_last_q;
      out_cnt_d  = pend_cnt_q;
    end else if (m_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      slot_q  <= 1'b0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      k_q     <= k_d;
      slot_q  <= slot_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    pend_cnt_q  <= pend_cnt_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign ram_raddr_o   = {slot_q, idx[IW-1:0]};
  assign m_valid_o     = out_v_q;
  assign digit_char_o  = out_char_q;
  assign last_o        = out_last_q;
  assign digit_count_o = out_cnt_q;

endmodule
